@@ sv/sebt_pkg.sv @@
// Shared types, sizes and codes for the shared/exclusive borrow table.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sebt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int COUNT_BITS    = 16;

   localparam int IDX_BITS     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int OCC_BITS     = $clog2(TABLE_ENTRIES + 1);
   localparam int OCC_WIDE     = (OCC_BITS > 5) ? OCC_BITS : 5;
   localparam int SH_WIDE_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   localparam int ENTITY_BITS = 64;
   localparam int MODE_BITS   = 3;
   localparam int STATUS_BITS = 3;
   localparam int SHOUT_BITS  = 16;
   localparam int USE_BITS    = 5;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ACQ_SHARED  = 3'd0,
      MODE_ACQ_EXCL    = 3'd1,
      MODE_RELEASE_ONE = 3'd2,
      MODE_RELEASE_ALL = 3'd3,
      MODE_QUERY       = 3'd4
   } mode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK              = 3'd0,
      ST_UNTRACKED       = 3'd1,
      ST_FULL            = 3'd2,
      ST_SHARED_CONFLICT = 3'd3,
      ST_EXCL_CONFLICT   = 3'd4,
      ST_SATURATED       = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_UPDATE
   } state_type;

   typedef struct packed {
      logic load;
      logic match;
      logic update;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

@@ sv/shared_exclusive_borrow_table_unit.sv @@
// Top level of the shared/exclusive borrow table: joins the controller and the
// datapath. Depends on sebt_pkg, sebt_ctrl and sebt_datapath.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_mode, req_entity_id
//   rsp_      out        rsp_valid/rsp_stall   rsp_status, rsp_granted, rsp_shared_now,
//                                              rsp_exclusive_now, rsp_entries_in_use
//
// Each request goes through a match step, the parallel match and free-slot search over
// the slot table, and then an update step, the read-modify-write of the selected slot.
// The result lands in a response register; the next request is taken in the
// update step, so a new request is accepted while the previous one is being written.
// A stalled response holds the update step until the register drains.
// Synchronous reset empties the table.
`timescale 1ns / 1ps
`default_nettype none

module shared_exclusive_borrow_table_unit
   import sebt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [MODE_BITS-1:0]   req_mode,
   input  wire logic [ENTITY_BITS-1:0] req_entity_id,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [STATUS_BITS-1:0] rsp_status,
   output      logic                   rsp_granted,
   output      logic [SHOUT_BITS-1:0]  rsp_shared_now,
   output      logic                   rsp_exclusive_now,
   output      logic [USE_BITS-1:0]    rsp_entries_in_use
);

   ctrl_cmd_type cmd;

   sebt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   sebt_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_mode           (req_mode),
      .req_entity_id      (req_entity_id),
      .rsp_status         (rsp_status),
      .rsp_granted        (rsp_granted),
      .rsp_shared_now     (rsp_shared_now),
      .rsp_exclusive_now  (rsp_exclusive_now),
      .rsp_entries_in_use (rsp_entries_in_use)
   );

endmodule

`default_nettype wire

@@ sv/sebt_ctrl.sv @@
// Controller for the borrow table: request handshake, match/update sequencing
// and the response valid flag. Depends on sebt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sebt_ctrl
   import sebt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      ctrl_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The response register can take a new result when it is empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_MATCH;
         end
         S_MATCH: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) state_in = req_valid ? S_MATCH : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      cmd.match  = 1'b0;
      cmd.update = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
         end
         S_MATCH: begin
            cmd.match = 1'b1;
         end
         S_UPDATE: begin
            req_stall  = !out_free;
            cmd.update = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      cmd.load = req_valid && !req_stall;
   end

   assign rsp_valid_in = cmd.update || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_match_then_update: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MATCH |=> state_ff == S_UPDATE)
      else $error("match cycle not followed by update");
   a_update_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid_ff)
      else $error("update did not present a response");
   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == S_IDLE || cmd.update))
      else $error("request taken while an item is in flight");
`endif

endmodule

`default_nettype wire

@@ sv/sebt_datapath.sv @@
// Datapath for the borrow table: slot registers, parallel match and free-slot
// search, read-modify-write of one slot and the response register. Depends on sebt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sebt_datapath
   import sebt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctrl_cmd_type           cmd,
   input  wire logic [MODE_BITS-1:0]   req_mode,
   input  wire logic [ENTITY_BITS-1:0] req_entity_id,
   output      logic [STATUS_BITS-1:0] rsp_status,
   output      logic                   rsp_granted,
   output      logic [SHOUT_BITS-1:0]  rsp_shared_now,
   output      logic                   rsp_exclusive_now,
   output      logic [USE_BITS-1:0]    rsp_entries_in_use
);

   // Captured request.
   logic [MODE_BITS-1:0]   mode_ff;
   logic [ENTITY_BITS-1:0] id_ff;

   // Slot table.
   logic [ENTITY_BITS-1:0] slot_entity_ff [TABLE_ENTRIES];
   logic [COUNT_BITS-1:0]  slot_shared_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] slot_exclusive_ff;
   logic [TABLE_ENTRIES-1:0] slot_occupied_ff;
   logic [OCC_BITS-1:0]    total_ff, total_in;

   // Match results.
   logic [TABLE_ENTRIES-1:0] match_vec;
   logic                   hit_in, free_ok_in;
   logic [IDX_BITS-1:0]    hit_idx_in, free_idx_in;
   logic                   hit_ff, free_ok_ff;
   logic [IDX_BITS-1:0]    hit_idx_ff, free_idx_ff;

   // Update.
   logic [IDX_BITS-1:0]    sel_idx;
   logic [COUNT_BITS-1:0]  cur_sh, new_sh;
   logic                   cur_ex, new_ex;
   status_type             st;
   logic                   granted, wr_en, claim, release_slot, res_slot;
   logic [SH_WIDE_BITS-1:0] sh_wide;
   logic [OCC_WIDE-1:0]    total_wide;

   // Response register.
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic                   rsp_granted_ff, rsp_exclusive_ff;
   logic [SHOUT_BITS-1:0]  rsp_shared_ff;
   logic [USE_BITS-1:0]    rsp_use_ff;

   always_comb begin
      hit_in      = 1'b0;
      free_ok_in  = 1'b0;
      hit_idx_in  = '0;
      free_idx_in = '0;
      // Walk downward so the lowest free slot wins.
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         match_vec[i] = slot_occupied_ff[i] && (slot_entity_ff[i] == id_ff);
         if (match_vec[i]) begin
            hit_in     = 1'b1;
            hit_idx_in = IDX_BITS'(i);
         end
         if (!slot_occupied_ff[i]) begin
            free_ok_in  = 1'b1;
            free_idx_in = IDX_BITS'(i);
         end
      end
   end

   assign sel_idx = hit_ff ? hit_idx_ff : free_idx_ff;
   assign cur_sh  = hit_ff ? slot_shared_ff[sel_idx] : '0;
   assign cur_ex  = hit_ff && slot_exclusive_ff[sel_idx];

   always_comb begin
      st           = ST_OK;
      granted      = 1'b0;
      new_sh       = cur_sh;
      new_ex       = cur_ex;
      wr_en        = 1'b0;
      claim        = 1'b0;
      release_slot = 1'b0;
      res_slot     = hit_ff;
      unique case (mode_type'(mode_ff)) inside
         MODE_ACQ_SHARED, MODE_ACQ_EXCL: begin
            if (!hit_ff && !free_ok_ff) begin
               st       = ST_FULL;
               res_slot = 1'b0;
            end else begin
               res_slot = 1'b1;
               claim    = !hit_ff;
               wr_en    = 1'b1;
               if (mode_ff == MODE_ACQ_SHARED) begin
                  if (cur_ex) begin
                     st = ST_SHARED_CONFLICT;
                  end else if (cur_sh == COUNT_MAX) begin
                     st = ST_SATURATED;
                  end else begin
                     new_sh  = cur_sh + 1'b1;
                     granted = 1'b1;
                  end
               end else begin
                  if (cur_ex || (cur_sh != '0)) begin
                     st = ST_EXCL_CONFLICT;
                  end else begin
                     new_ex  = 1'b1;
                     granted = 1'b1;
                  end
               end
            end
         end
         MODE_RELEASE_ONE: begin
            if (!hit_ff) begin
               st = ST_UNTRACKED;
            end else begin
               wr_en = 1'b1;
               if (cur_ex) begin
                  new_ex = 1'b0;
               end else if (cur_sh != '0) begin
                  new_sh = cur_sh - 1'b1;
               end
               if (!new_ex && (new_sh == '0)) begin
                  release_slot = 1'b1;
                  res_slot     = 1'b0;
               end
            end
         end
         MODE_RELEASE_ALL: begin
            if (!hit_ff) begin
               st = ST_UNTRACKED;
            end else begin
               wr_en        = 1'b1;
               release_slot = 1'b1;
               res_slot     = 1'b0;
               new_sh       = '0;
               new_ex       = 1'b0;
            end
         end
         default: begin
            // Query, and the unused mode codes that behave as a query.
            if (!hit_ff) st = ST_UNTRACKED;
         end
      endcase
   end

   always_comb begin
      total_in = total_ff;
      if (claim) begin
         total_in = total_ff + 1'b1;
      end else if (release_slot && (total_ff != '0)) begin
         total_in = total_ff - 1'b1;
      end
   end

   assign sh_wide    = res_slot ? SH_WIDE_BITS'(new_sh) : '0;
   assign total_wide = OCC_WIDE'(total_in);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         id_ff   <= req_entity_id;
      end
      if (cmd.match) begin
         hit_ff      <= hit_in;
         hit_idx_ff  <= hit_idx_in;
         free_ok_ff  <= free_ok_in;
         free_idx_ff <= free_idx_in;
      end
      if (cmd.update) begin
         rsp_status_ff    <= st;
         rsp_granted_ff   <= granted;
         rsp_shared_ff    <= (sh_wide > SH_WIDE_BITS'(16'hFFFF)) ? 16'hFFFF
                                                                  : sh_wide[SHOUT_BITS-1:0];
         rsp_exclusive_ff <= res_slot && new_ex;
         rsp_use_ff       <= total_wide[USE_BITS-1:0];
      end
      if (cmd.update && wr_en) begin
         slot_shared_ff[sel_idx] <= release_slot ? '0 : new_sh;
         if (claim) slot_entity_ff[sel_idx] <= id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_occupied_ff  <= '0;
         slot_exclusive_ff <= '0;
         total_ff          <= '0;
      end else if (cmd.update && wr_en) begin
         slot_exclusive_ff[sel_idx] <= !release_slot && new_ex;
         slot_occupied_ff[sel_idx]  <= !release_slot;
         total_ff                   <= total_in;
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_shared_now     = rsp_shared_ff;
   assign rsp_exclusive_now  = rsp_exclusive_ff;
   assign rsp_entries_in_use = rsp_use_ff;

`ifndef SYNTHESIS
   a_total_matches_slots: assert property (@(posedge clock) disable iff (reset)
      OCC_BITS'($countones(slot_occupied_ff)) == total_ff)
      else $error("occupied count out of step with slot flags");
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      cmd.match |-> $onehot0(match_vec))
      else $error("entity tracked in more than one slot");
   a_no_dead_claim: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && claim) |-> (granted && free_ok_ff && !hit_ff))
      else $error("slot claimed without a granted acquire");
`endif

endmodule

`default_nettype wire

@@ tb/sv/borrow_table_checker.sv @@
// Checker for the shared/exclusive borrow table: watches both channels, predicts every result
// from its own copy of the slot table and compares each response with the oldest prediction.
// Depends on sebt_pkg.
`timescale 1ns / 1ps

module borrow_table_checker
   import sebt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [MODE_BITS-1:0]   req_mode,
   input  logic [ENTITY_BITS-1:0] req_entity_id,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [STATUS_BITS-1:0] rsp_status,
   input  logic                   rsp_granted,
   input  logic [SHOUT_BITS-1:0]  rsp_shared_now,
   input  logic                   rsp_exclusive_now,
   input  logic [USE_BITS-1:0]    rsp_entries_in_use,
   output int                     fail_count,
   output int                     pending_results
);

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic                   granted;
      logic [SHOUT_BITS-1:0]  shared_now;
      logic                   exclusive_now;
      logic [USE_BITS-1:0]    entries_in_use;
   } borrow_result_type;

   logic [ENTITY_BITS-1:0] slot_id     [TABLE_ENTRIES];
   logic [COUNT_BITS-1:0]  slot_shared [TABLE_ENTRIES];
   logic                   slot_excl   [TABLE_ENTRIES];
   logic                   slot_used   [TABLE_ENTRIES];
   int                     used_total;

   borrow_result_type expected_borrows[$];
   int                error_total = 0;

   initial begin
      fail_count      = 0;
      pending_results = 0;
   end

   task automatic clear_table();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         slot_id[i]     = '0;
         slot_shared[i] = '0;
         slot_excl[i]   = 1'b0;
         slot_used[i]   = 1'b0;
      end
      used_total = 0;
   endtask

   function automatic void free_entry(input int s);
      slot_shared[s] = '0;
      slot_excl[s]   = 1'b0;
      slot_used[s]   = 1'b0;
      if (used_total > 0) used_total--;
   endfunction

   // Applies one request to the local table and returns the response it must produce.
   function automatic borrow_result_type predict_borrow(input logic [MODE_BITS-1:0]   mode,
                                                        input logic [ENTITY_BITS-1:0] id);
      int                hit;
      borrow_result_type r;
      logic [31:0]       wide;
      hit = -1;
      r   = '0;
      r.status = ST_OK;
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (hit < 0 && slot_used[i] && slot_id[i] == id) hit = i;
      case (mode) inside
         MODE_ACQ_SHARED, MODE_ACQ_EXCL: begin
            // An unknown entity takes the lowest free slot before the acquire is judged.
            if (hit < 0)
               for (int i = 0; i < TABLE_ENTRIES; i++)
                  if (hit < 0 && !slot_used[i]) begin
                     hit            = i;
                     slot_id[i]     = id;
                     slot_shared[i] = '0;
                     slot_excl[i]   = 1'b0;
                     slot_used[i]   = 1'b1;
                     used_total++;
                  end
            if (hit < 0) begin
               r.status = ST_FULL;
            end else if (mode == MODE_ACQ_SHARED) begin
               if (slot_excl[hit]) r.status = ST_SHARED_CONFLICT;
               else if (slot_shared[hit] == COUNT_MAX) r.status = ST_SATURATED;
               else begin
                  slot_shared[hit]++;
                  r.granted = 1'b1;
               end
            end else begin
               if (slot_excl[hit] || slot_shared[hit] != '0) r.status = ST_EXCL_CONFLICT;
               else begin
                  slot_excl[hit] = 1'b1;
                  r.granted      = 1'b1;
               end
            end
         end
         MODE_RELEASE_ONE: begin
            if (hit < 0) begin
               r.status = ST_UNTRACKED;
            end else begin
               if (slot_excl[hit]) slot_excl[hit] = 1'b0;
               else if (slot_shared[hit] != '0) slot_shared[hit]--;
               if (!slot_excl[hit] && slot_shared[hit] == '0) begin
                  free_entry(hit);
                  hit = -1;
               end
            end
         end
         MODE_RELEASE_ALL: begin
            if (hit < 0) begin
               r.status = ST_UNTRACKED;
            end else begin
               free_entry(hit);
               hit = -1;
            end
         end
         default: begin
            // Query, and the unused modes that behave as a query.
            if (hit < 0) r.status = ST_UNTRACKED;
         end
      endcase
      if (hit >= 0) begin
         wide            = 32'(slot_shared[hit]);
         r.shared_now    = (wide > 32'hFFFF) ? 16'hFFFF : wide[15:0];
         r.exclusive_now = slot_excl[hit];
      end
      r.entries_in_use = used_total[USE_BITS-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_total++;
      end
   endtask

   always @(posedge clock) begin
      borrow_result_type want;
      if (reset) begin
         clear_table();
         expected_borrows.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_borrows.size() == 0) begin
               $display("%0t: response with no request waiting, expected none, got status %0d",
                        $time, rsp_status);
               error_total++;
            end else begin
               want = expected_borrows.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_status));
               check_field("granted", 16'(want.granted), 16'(rsp_granted));
               check_field("shared_now", want.shared_now, rsp_shared_now);
               check_field("exclusive_now", 16'(want.exclusive_now), 16'(rsp_exclusive_now));
               check_field("entries_in_use", 16'(want.entries_in_use),
                           16'(rsp_entries_in_use));
            end
         end
         if (req_valid && !req_stall)
            expected_borrows.push_back(predict_borrow(req_mode, req_entity_id));
      end
      fail_count      <= error_total;
      pending_results <= expected_borrows.size();
   end

endmodule

@@ tb/sv/tb_shared_exclusive_borrow_table_unit.sv @@
// Top of the borrow table testbench: clock, reset, request and response drivers and the verdict.
// Depends on sebt_pkg, shared_exclusive_borrow_table_unit and borrow_table_checker.
`timescale 1ns / 1ps

module tb_shared_exclusive_borrow_table_unit
   import sebt_pkg::*;
();

   localparam int              POOL_SIZE         = 24;
   localparam int              CYCLE_LIMIT       = 1000000;
   localparam logic [MODE_BITS-1:0] MODE_UNUSED_FIRST = 3'd5;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [MODE_BITS-1:0]   req_mode;
   logic [ENTITY_BITS-1:0] req_entity_id;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [STATUS_BITS-1:0] rsp_status;
   logic                   rsp_granted;
   logic [SHOUT_BITS-1:0]  rsp_shared_now;
   logic                   rsp_exclusive_now;
   logic [USE_BITS-1:0]    rsp_entries_in_use;
   int                     fail_count;
   int                     pending_results;

   int                     gap_pct   = 0;
   int                     stall_pct = 0;
   int                     hold_left = 0;
   int                     cycle_count;
   logic [ENTITY_BITS-1:0] entity_pool[POOL_SIZE];
   int                     pool_used = POOL_SIZE;

   shared_exclusive_borrow_table_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_entity_id      (req_entity_id),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_granted        (rsp_granted),
      .rsp_shared_now     (rsp_shared_now),
      .rsp_exclusive_now  (rsp_exclusive_now),
      .rsp_entries_in_use (rsp_entries_in_use)
   );

   borrow_table_checker borrow_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_entity_id      (req_entity_id),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_granted        (rsp_granted),
      .rsp_shared_now     (rsp_shared_now),
      .rsp_exclusive_now  (rsp_exclusive_now),
      .rsp_entries_in_use (rsp_entries_in_use),
      .fail_count         (fail_count),
      .pending_results    (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: random stalls, or a long hold-off when one is requested.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Offers one request, with random idle cycles first, and returns at the edge that takes it.
   task automatic send_request(input logic [MODE_BITS-1:0] m, input logic [ENTITY_BITS-1:0] id);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= m;
      req_entity_id <= id;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   // Drops every borrow held by the current pool, then draws a fresh pool.
   task automatic refresh_pool(input int size);
      for (int i = 0; i < POOL_SIZE; i++) send_request(MODE_RELEASE_ALL, entity_pool[i]);
      for (int i = 0; i < POOL_SIZE; i++) entity_pool[i] = {$urandom, $urandom};
      pool_used = size;
   endtask

   task automatic random_requests(input int count);
      int                     pick;
      int                     burst;
      logic [ENTITY_BITS-1:0] id;
      logic [MODE_BITS-1:0]   m;
      repeat (count) begin
         pick = $urandom_range(99);
         id   = entity_pool[$urandom_range(pool_used - 1)];
         if (pick < 8) begin
            // A well-formed borrow: one to four shared acquires, then as many releases.
            burst = $urandom_range(1, 4);
            repeat (burst) send_request(MODE_ACQ_SHARED, id);
            repeat (burst) send_request(MODE_RELEASE_ONE, id);
         end else begin
            if (pick < 35) m = MODE_ACQ_SHARED;
            else if (pick < 52) m = MODE_ACQ_EXCL;
            else if (pick < 75) m = MODE_RELEASE_ONE;
            else if (pick < 84) m = MODE_RELEASE_ALL;
            else if (pick < 93) m = MODE_QUERY;
            else if (pick < 97) m = MODE_UNUSED_FIRST + 3'($urandom_range(2));
            else begin
               // Noise on an entity that is almost surely not tracked.
               m  = (pick < 98) ? MODE_RELEASE_ONE : MODE_QUERY;
               id = {$urandom, $urandom};
            end
            send_request(m, id);
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mode      = MODE_QUERY;
      req_entity_id = '0;
      entity_pool[0] = '0;
      entity_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) entity_pool[i] = {$urandom, $urandom};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: untracked entity, both conflicts, unused modes, release to free, full table.
      send_request(MODE_QUERY, entity_pool[0]);
      send_request(MODE_RELEASE_ONE, entity_pool[0]);
      send_request(MODE_RELEASE_ALL, entity_pool[1]);
      send_request(MODE_ACQ_SHARED, entity_pool[0]);
      send_request(MODE_ACQ_SHARED, entity_pool[0]);
      send_request(MODE_ACQ_EXCL, entity_pool[0]);
      send_request(MODE_RELEASE_ONE, entity_pool[0]);
      send_request(MODE_ACQ_EXCL, entity_pool[1]);
      send_request(MODE_ACQ_SHARED, entity_pool[1]);
      send_request(MODE_ACQ_EXCL, entity_pool[1]);
      send_request(MODE_UNUSED_FIRST, entity_pool[1]);
      send_request(MODE_UNUSED_FIRST + 3'd1, entity_pool[0]);
      send_request(MODE_UNUSED_FIRST + 3'd2, entity_pool[2]);
      send_request(MODE_RELEASE_ONE, entity_pool[1]);
      for (int i = 2; i <= TABLE_ENTRIES; i++)
         send_request((i % 2) ? MODE_ACQ_EXCL : MODE_ACQ_SHARED, entity_pool[i]);
      send_request(MODE_ACQ_SHARED, entity_pool[TABLE_ENTRIES + 1]);
      send_request(MODE_ACQ_EXCL, entity_pool[TABLE_ENTRIES + 2]);
      wait_for_results();

      random_requests(150);
      wait_for_results();

      gap_pct = 74;
      refresh_pool($urandom_range(6, POOL_SIZE));
      random_requests(150);
      wait_for_results();

      gap_pct   = 0;
      stall_pct = 74;
      refresh_pool($urandom_range(6, POOL_SIZE));
      random_requests(150);
      wait_for_results();

      gap_pct   = 19;
      stall_pct = 19;
      refresh_pool(POOL_SIZE);
      random_requests(150);
      wait_for_results();

      // Long hold-off on responses while requests keep coming, so the input backs up.
      gap_pct   = 0;
      stall_pct = 0;
      hold_left = 300;
      random_requests(40);
      wait_for_results();

      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/sebt_pkg.sv
sv/sebt_ctrl.sv
sv/sebt_datapath.sv
sv/shared_exclusive_borrow_table_unit.sv
tb/sv/borrow_table_checker.sv
tb/sv/tb_shared_exclusive_borrow_table_unit.sv
